### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PMHR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PMHR_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define PMHR_ASSERT(lbl, clk, rst_n, prop)
`define PMHR_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

### sv/pmhr_pkg.sv
// ---------------------------------------------------------------------------
// Hop reply classifier package
// Shared constants, pipeline stage types and mask helper.
// ---------------------------------------------------------------------------
package pmhr_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = 4;
    localparam int CNT_W = 5;

    localparam logic [3:0] VER_V4 = 4'd4;
    localparam logic [3:0] VER_V6 = 4'd6;
    localparam logic [3:0] IHL_MIN = 4'd5;
    localparam logic [7:0] VER_MASK = 8'hf0;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_ICMP6 = 8'd58;
    localparam logic [7:0] ECHO_V4 = 8'd8;
    localparam logic [7:0] ECHO_V6 = 8'd128;
    localparam logic [7:0] FLAG_SYN = 8'h02;
    localparam logic [31:0] LOW32 = 32'hffffffff;

    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_TIME = 3'd1;
    localparam logic [2:0] KIND_ECHO = 3'd2;
    localparam logic [2:0] KIND_RST = 3'd3;
    localparam logic [2:0] KIND_UNREACH = 3'd4;

    typedef struct packed {
        logic        op;
        logic [7:0]  first_byte;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [7:0]  hop_limit;
        logic [7:0]  next_proto;
        logic [7:0]  icmp_type;
        logic [7:0]  tcp_flags;
        logic [31:0] tcp_seq;
        logic [3:0]  entry_index;
        logic        entry_family;
        logic [7:0]  entry_prefix;
    } t_item;

    typedef struct packed {
        logic        valid;
        logic        found;
        logic        is_v6;
        logic [63:0] base_hi;
        logic [63:0] base_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [7:0]  hop;
        logic [7:0]  proto;
        logic [7:0]  itype;
        logic [7:0]  flags;
        logic [31:0] seq;
    } t_s1;

    typedef struct packed {
        logic        valid;
        logic        found;
        logic        is_v6;
        logic        in_range;
        logic [63:0] time_hi;
        logic [63:0] time_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [7:0]  proto;
        logic [7:0]  itype;
        logic [7:0]  flags;
        logic [31:0] seq;
    } t_s2;

    function automatic logic [63:0] top_mask64(input logic [7:0] n);
        logic [63:0] m;
        if (n == 8'd0) begin
            m = 64'd0;
        end else if (n >= 8'd64) begin
            m = ~64'd0;
        end else begin
            m = ~64'd0 << (8'd64 - n);
        end
        return m;
    endfunction

endpackage

### sv/prefix_match_hop_reply_classifier_top.sv
// An accepted item passes through the match, range and reply stage registers in order before its result is valid.
// Throughput: one item per cycle; the three-stage pipeline stalls as a whole
// while the output register holds an untaken result.
// Reset clears the stage valid bits and entries_in_use; table entries
// are undefined until written.
// ---------------------------------------------------------------------------
// Prefix match hop reply classifier
// Prefix table lookup, hop window check and reply selection.
// ---------------------------------------------------------------------------
module prefix_match_hop_reply_classifier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [7:0]  i_first_byte,
    input  logic [63:0] i_addr_hi,
    input  logic [63:0] i_addr_lo,
    input  logic [7:0]  i_hop_limit,
    input  logic [7:0]  i_next_proto,
    input  logic [7:0]  i_icmp_type,
    input  logic [7:0]  i_tcp_flags,
    input  logic [31:0] i_tcp_seq,
    input  logic [3:0]  i_entry_index,
    input  logic        i_entry_family,
    input  logic [7:0]  i_entry_prefix,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_reply_kind,
    output logic        o_reply_is_v6,
    output logic [63:0] o_reply_src_hi,
    output logic [63:0] o_reply_src_lo,
    output logic [31:0] o_ack_number
);

    pmhr_pkg::t_item item;
    pmhr_pkg::t_s1   s1;
    pmhr_pkg::t_s2   s2;
    logic            en;
    logic            take;

    assign en = !o_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign take = i_in_valid && en;

    assign item.op = i_op;
    assign item.first_byte = i_first_byte;
    assign item.addr_hi = i_addr_hi;
    assign item.addr_lo = i_addr_lo;
    assign item.hop_limit = i_hop_limit;
    assign item.next_proto = i_next_proto;
    assign item.icmp_type = i_icmp_type;
    assign item.tcp_flags = i_tcp_flags;
    assign item.tcp_seq = i_tcp_seq;
    assign item.entry_index = i_entry_index;
    assign item.entry_family = i_entry_family;
    assign item.entry_prefix = i_entry_prefix;

    pmhr_match u_match (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_take     (take),
        .i_item     (item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_s1       (s1)
    );

    pmhr_range u_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_s1    (s1),
        .o_s2    (s2)
    );

    pmhr_reply u_reply (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_s2     (s2),
        .o_valid  (o_out_valid),
        .o_kind   (o_reply_kind),
        .o_is_v6  (o_reply_is_v6),
        .o_src_hi (o_reply_src_hi),
        .o_src_lo (o_reply_src_lo),
        .o_ack    (o_ack_number)
    );

endmodule

### sv/pmhr_match.sv
// ---------------------------------------------------------------------------
// Prefix match stage
// Holds the prefix table and finds the first matching entry of an item.
// ---------------------------------------------------------------------------
module pmhr_match (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_take,
    input  pmhr_pkg::t_item            i_item,
    input  logic                       i_cfg_we,
    input  logic [4:0]                 i_cfg_data,
    output pmhr_pkg::t_s1              o_s1
);

    logic [63:0] r_ent_hi [pmhr_pkg::TABLE_ENTRIES];
    logic [63:0] r_ent_lo [pmhr_pkg::TABLE_ENTRIES];
    logic [7:0]  r_ent_len [pmhr_pkg::TABLE_ENTRIES];
    logic        r_ent_v6 [pmhr_pkg::TABLE_ENTRIES];
    logic [4:0]  r_in_use;
    pmhr_pkg::t_s1 r_s1;
    pmhr_pkg::t_s1 n_s1;

    logic [pmhr_pkg::CNT_W-1:0] n_count;
    logic [3:0] ver;
    logic hdr_v4;
    logic hdr_v6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= 5'd0;
        end else if (i_cfg_we) begin
            r_in_use <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_item.op) begin
            r_ent_hi[i_item.entry_index[pmhr_pkg::IDX_W-1:0]] <= i_item.addr_hi;
            r_ent_lo[i_item.entry_index[pmhr_pkg::IDX_W-1:0]] <= i_item.addr_lo;
            r_ent_len[i_item.entry_index[pmhr_pkg::IDX_W-1:0]] <= i_item.entry_prefix;
            r_ent_v6[i_item.entry_index[pmhr_pkg::IDX_W-1:0]] <= i_item.entry_family;
        end
    end

    always_comb begin
        logic [7:0]  l;
        logic [63:0] mh;
        logic [63:0] ml;
        logic [31:0] m4;
        logic        hit;
        l = 8'd0;
        mh = 64'd0;
        ml = 64'd0;
        m4 = 32'd0;
        hit = 1'b0;
        n_count = (r_in_use > pmhr_pkg::CNT_W'(pmhr_pkg::TABLE_ENTRIES))
                ? pmhr_pkg::CNT_W'(pmhr_pkg::TABLE_ENTRIES) : r_in_use;
        ver = 4'((i_item.first_byte & pmhr_pkg::VER_MASK) >> 4);
        hdr_v4 = !i_item.op && ver == pmhr_pkg::VER_V4
               && i_item.first_byte[3:0] == pmhr_pkg::IHL_MIN;
        hdr_v6 = !i_item.op && ver == pmhr_pkg::VER_V6;
        n_s1.valid = i_take;
        n_s1.found = 1'b0;
        n_s1.is_v6 = hdr_v6;
        n_s1.base_hi = 64'd0;
        n_s1.base_lo = 64'd0;
        n_s1.dst_hi = i_item.addr_hi;
        n_s1.dst_lo = i_item.addr_lo;
        n_s1.hop = i_item.hop_limit;
        n_s1.proto = i_item.next_proto;
        n_s1.itype = i_item.icmp_type;
        n_s1.flags = i_item.tcp_flags;
        n_s1.seq = i_item.tcp_seq;
        // scan from the top so the lowest matching entry wins
        for (int i = pmhr_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_ent_v6[i]) begin
                l = (r_ent_len[i] > 8'd128) ? 8'd128 : r_ent_len[i];
                mh = pmhr_pkg::top_mask64((l > 8'd64) ? 8'd64 : l);
                ml = pmhr_pkg::top_mask64((l > 8'd64) ? l - 8'd64 : 8'd0);
                hit = hdr_v6 && ((r_ent_hi[i] & mh) == (i_item.addr_hi & mh))
                    && ((r_ent_lo[i] & ml) == (i_item.addr_lo & ml));
            end else begin
                l = (r_ent_len[i] > 8'd32) ? 8'd32 : r_ent_len[i];
                mh = pmhr_pkg::top_mask64(l);
                m4 = mh[63:32];
                ml = 64'd0;
                hit = hdr_v4 && ((r_ent_lo[i][31:0] & m4) == (i_item.addr_lo[31:0] & m4));
            end
            if (hit && pmhr_pkg::CNT_W'(i) < n_count) begin
                n_s1.found = r_ent_v6[i] || (r_ent_lo[i][31:0] != 32'd0);
                n_s1.base_hi = r_ent_hi[i];
                n_s1.base_lo = r_ent_lo[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

### sv/pmhr_range.sv
// ---------------------------------------------------------------------------
// Hop range stage
// Forms base plus hop and checks the destination against the hop window.
// ---------------------------------------------------------------------------
module pmhr_range (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  pmhr_pkg::t_s1      i_s1,
    output pmhr_pkg::t_s2      o_s2
);

    pmhr_pkg::t_s2 r_s2;
    pmhr_pkg::t_s2 n_s2;

    always_comb begin
        logic [31:0] b;
        logic [31:0] d;
        logic [31:0] top;
        b = i_s1.base_lo[31:0];
        d = i_s1.dst_lo[31:0];
        top = b + {24'd0, i_s1.hop};
        n_s2.valid = i_s1.valid;
        n_s2.found = i_s1.found;
        n_s2.is_v6 = i_s1.is_v6;
        n_s2.in_range = (b <= d) && (top >= d);
        n_s2.time_hi = i_s1.is_v6 ? i_s1.base_hi : 64'd0;
        n_s2.time_lo = i_s1.is_v6 ? {i_s1.base_lo[63:32], top} : {32'd0, top};
        n_s2.dst_hi = i_s1.is_v6 ? i_s1.dst_hi : 64'd0;
        n_s2.dst_lo = i_s1.is_v6 ? i_s1.dst_lo : {32'd0, d};
        n_s2.proto = i_s1.proto;
        n_s2.itype = i_s1.itype;
        n_s2.flags = i_s1.flags;
        n_s2.seq = i_s1.seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

### sv/pmhr_reply.sv
// ---------------------------------------------------------------------------
// Reply select stage
// Picks the reply kind and drives the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module pmhr_reply (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  pmhr_pkg::t_s2      i_s2,
    output logic               o_valid,
    output logic [2:0]         o_kind,
    output logic               o_is_v6,
    output logic [63:0]        o_src_hi,
    output logic [63:0]        o_src_lo,
    output logic [31:0]        o_ack
);

    logic        r_valid;
    logic [2:0]  r_kind;
    logic        r_is_v6;
    logic [63:0] r_src_hi;
    logic [63:0] r_src_lo;
    logic [31:0] r_ack;
    logic [2:0]  n_kind;
    logic        n_is_v6;
    logic [63:0] n_src_hi;
    logic [63:0] n_src_lo;
    logic [31:0] n_ack;

    always_comb begin
        logic echo;
        echo = i_s2.is_v6
             ? (i_s2.proto == pmhr_pkg::PROTO_ICMP6 && i_s2.itype == pmhr_pkg::ECHO_V6)
             : (i_s2.proto == pmhr_pkg::PROTO_ICMP && i_s2.itype == pmhr_pkg::ECHO_V4);
        n_kind = pmhr_pkg::KIND_NONE;
        n_ack = 32'd0;
        n_src_hi = i_s2.dst_hi;
        n_src_lo = i_s2.dst_lo;
        if (!i_s2.in_range) begin
            n_kind = pmhr_pkg::KIND_TIME;
            n_src_hi = i_s2.time_hi;
            n_src_lo = i_s2.time_lo;
        end else if (echo) begin
            n_kind = pmhr_pkg::KIND_ECHO;
        end else if (i_s2.proto == pmhr_pkg::PROTO_TCP) begin
            if (i_s2.flags == pmhr_pkg::FLAG_SYN) begin
                n_kind = pmhr_pkg::KIND_RST;
                n_ack = i_s2.seq + 32'd1;
            end
        end else begin
            n_kind = pmhr_pkg::KIND_UNREACH;
        end
        if (!i_s2.found) begin
            n_kind = pmhr_pkg::KIND_NONE;
        end
        n_is_v6 = i_s2.is_v6;
        if (n_kind == pmhr_pkg::KIND_NONE) begin
            n_is_v6 = 1'b0;
            n_src_hi = 64'd0;
            n_src_lo = 64'd0;
            n_ack = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_s2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kind <= n_kind;
            r_is_v6 <= n_is_v6;
            r_src_hi <= n_src_hi;
            r_src_lo <= n_src_lo;
            r_ack <= n_ack;
        end
    end

    assign o_valid = r_valid;
    assign o_kind = r_kind;
    assign o_is_v6 = r_is_v6;
    assign o_src_hi = r_src_hi;
    assign o_src_lo = r_src_lo;
    assign o_ack = r_ack;

    `PMHR_ASSERT(a_none_zero, i_clk, i_rst_n, (r_valid && r_kind == pmhr_pkg::KIND_NONE) |-> (!r_is_v6 && r_src_hi == 64'd0 && r_src_lo == 64'd0))
    `PMHR_ASSERT(a_ack_rst_only, i_clk, i_rst_n, (r_valid && r_kind != pmhr_pkg::KIND_RST) |-> (r_ack == 32'd0))
    `PMHR_ASSERT_NEXT(a_not_found, i_clk, i_rst_n, (i_en && i_s2.valid && !i_s2.found), (r_kind == pmhr_pkg::KIND_NONE))

endmodule
